// ===== rtl/keyframe_curve_evaluator_top_macros.svh =====
// Assertion macros for the keyframe curve evaluator.
`ifndef KEYFRAME_CURVE_EVALUATOR_TOP_MACROS_SVH
`define KEYFRAME_CURVE_EVALUATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define KCE_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("kce assertion failed");
`define KCE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("kce assertion failed");
`else
`define KCE_ASSERT_SAME(lbl, ante, cons)
`define KCE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/kce_pkg.sv =====
// Shared types and constants of the keyframe curve evaluator.
package kce_pkg;
    localparam int TolLsb = 66;           // 0.001 frame in Q16.16
    localparam logic CmdLoad = 1'b0;
    localparam logic CmdEval = 1'b1;
    localparam logic CfgKeyCount  = 1'b0;
    localparam logic CfgCurveMode = 1'b1;
    localparam int KeyW = 96;

    typedef struct packed {
        logic [31:0] slope;
        logic [31:0] value;
        logic [31:0] frame;
    } t_key;
endpackage

// ===== rtl/kce_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module kce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/keyframe_curve_evaluator_top.sv =====
// Keyframe curve evaluator: key table, binary search, step and cubic Hermite output.
//
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tuser: command; tdata: index,frame,value,slope,query
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: curve_value, segment_left
// cfg       in   i_cfg_we (no wait)           i_cfg_index, i_cfg_data
//
// A load beat writes its key in the cycle it is accepted, and the block stays idle.
// An evaluate beat reads the first and last keys and stops there when it clamps; else it runs a
// binary search, then in Hermite mode a restoring divide and 8 products on one multiplier.
// Key reads go through one RAM read port, one per cycle, with the data in the next cycle.
// Reset (sync, active low) sets key_count 1, curve_mode Hermite; the key table is not cleared.
// A result held on m_axis does not block input; the next result waits for it.
module keyframe_curve_evaluator_top #(
    parameter int MAX_KEYS = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [135:0] s_axis_tdata,   // key_index[7:0], key_frame, key_value, key_slope, query_frame
    input  logic [0:0]   s_axis_tuser,   // command
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [39:0]  m_axis_tdata,   // curve_value[31:0], segment_left[39:32]
    input  logic         i_cfg_we,
    input  logic [0:0]   i_cfg_index,
    input  logic [8:0]   i_cfg_data
);
    localparam int AW = $clog2(MAX_KEYS);
    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam int NW = (CW > 9) ? CW : 9;
    localparam int XW = (NW > 8) ? NW : 8;
    localparam logic [NW-1:0] MaxN = NW'(MAX_KEYS);
    localparam logic [XW-1:0] MaxX = XW'(MAX_KEYS);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_K0    = 4'd1;
    localparam logic [3:0] S_KL    = 4'd2;
    localparam logic [3:0] S_PROBE = 4'd3;
    localparam logic [3:0] S_CMP   = 4'd4;
    localparam logic [3:0] S_RR    = 4'd5;
    localparam logic [3:0] S_R1    = 4'd6;
    localparam logic [3:0] S_LR    = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_MUL   = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    // multiplier ops, in order
    localparam logic [2:0] OpU2  = 3'd0;
    localparam logic [2:0] OpU3  = 3'd1;
    localparam logic [2:0] OpE10 = 3'd2;
    localparam logic [2:0] OpE11 = 3'd3;
    localparam logic [2:0] OpV0  = 3'd4;
    localparam logic [2:0] OpV1  = 3'd5;
    localparam logic [2:0] OpS0  = 3'd6;
    localparam logic [2:0] OpS1  = 3'd7;

    // control
    logic [3:0]   r_state, n_state;
    logic         r_out_valid;
    logic [8:0]   r_key_count;
    logic         r_curve_mode;

    // datapath
    logic [CW-1:0]       r_n;
    logic                r_hm;
    logic signed [31:0]  r_f;
    logic [AW-1:0]       r_left, r_right, r_seg;
    logic [31:0]         r_val;
    logic [31:0]         r_fr, r_vr, r_sr, r_vl, r_sl;
    logic [31:0]         r_d, r_q, r_dh;
    logic [32:0]         r_rem;
    logic [4:0]          r_cnt;
    logic [2:0]          r_op;
    logic                r_phase;
    logic [65:0]         r_prod;
    logic                r_neg;
    logic [31:0]         r_u2, r_u3;
    logic signed [33:0]  r_e10, r_e11;
    logic signed [53:0]  r_acc;
    logic [39:0]         r_out_data;

    kce_pkg::t_key w_wkey, w_rkey;
    logic [AW-1:0] w_raddr, w_waddr, w_mid, w_last;
    logic          w_in_acc, w_load, w_eval, w_we;
    logic [NW-1:0] w_kc;
    logic [CW-1:0] w_n_eff;

    assign w_in_acc = s_axis_tvalid && s_axis_tready;
    assign w_load   = w_in_acc && (s_axis_tuser[0] == kce_pkg::CmdLoad);
    assign w_eval   = w_in_acc && (s_axis_tuser[0] == kce_pkg::CmdEval);
    assign w_we     = w_load && (XW'(s_axis_tdata[7:0]) < MaxX);
    assign w_waddr  = AW'(s_axis_tdata[7:0]);
    assign w_wkey.frame = s_axis_tdata[39:8];
    assign w_wkey.value = s_axis_tdata[71:40];
    assign w_wkey.slope = s_axis_tdata[103:72];

    // key_count 0 acts as 1, above the table size as the table size
    assign w_kc = NW'(r_key_count);
    always_comb begin
        priority if (w_kc == '0) begin
            w_n_eff = CW'(1);
        end else if (w_kc > MaxN) begin
            w_n_eff = CW'(MAX_KEYS);
        end else begin
            w_n_eff = CW'(w_kc);
        end
    end

    assign w_last = AW'(r_n - CW'(1));
    assign w_mid  = AW'(({1'b0, r_left} + {1'b0, r_right}) >> 1);

    logic w_adjacent, w_has_next, w_near, w_go_right;
    logic signed [32:0] w_cdiff;
    assign w_adjacent = ({1'b0, r_left} + (AW+1)'(1)) == {1'b0, r_right};
    assign w_has_next = (CW'(r_right) + CW'(1)) < r_n;
    assign w_cdiff    = {r_f[31], r_f} - {w_rkey.frame[31], w_rkey.frame};
    assign w_near     = (w_cdiff > -33'(kce_pkg::TolLsb)) && (w_cdiff < 33'(kce_pkg::TolLsb));
    assign w_go_right = r_hm ? (r_f <= $signed(w_rkey.frame)) : (r_f < $signed(w_rkey.frame));

    always_comb begin
        unique case (r_state)
            S_K0:    w_raddr = w_last;
            S_PROBE: w_raddr = w_adjacent ? r_right : w_mid;
            S_RR:    w_raddr = (r_hm && w_near) ? AW'(r_right + AW'(1)) : r_left;
            default: w_raddr = '0;
        endcase
    end

    kce_ram #(
        .WIDTH (kce_pkg::KeyW),
        .DEPTH (MAX_KEYS)
    ) u_keys (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wkey),
        .i_raddr (w_raddr),
        .o_rdata (w_rkey)
    );

    // value from a key in the current mode: full Q16.16 or low 16 bits as integer
    logic [31:0] w_rkey_val;
    assign w_rkey_val = r_hm ? w_rkey.value : {16'b0, w_rkey.value[15:0]};

    // divider step: restoring, one quotient bit a cycle
    logic [32:0] w_rem_sh;
    logic        w_ge;
    assign w_rem_sh = {r_rem[31:0], r_dh[31]};
    assign w_ge     = w_rem_sh >= {1'b0, r_d};

    // Hermite basis weights, Q0.32 with headroom
    logic signed [35:0] w_u, w_u2, w_u3, w_h00, w_h01, w_h10, w_h11;
    assign w_u   = $signed({4'b0, r_q});
    assign w_u2  = $signed({4'b0, r_u2});
    assign w_u3  = $signed({4'b0, r_u3});
    assign w_h00 = (w_u3 <<< 1) - (w_u2 + (w_u2 <<< 1)) + 36'sh1_0000_0000;
    assign w_h01 = (w_u2 + (w_u2 <<< 1)) - (w_u3 <<< 1);
    assign w_h10 = w_u3 - (w_u2 <<< 1) + w_u;
    assign w_h11 = w_u3 - w_u2;

    // shared multiplier: sign-magnitude 33x33
    logic signed [35:0] w_opa, w_opb, w_maga, w_magb;
    logic [65:0]        w_mul;
    always_comb begin
        unique case (r_op)
            OpU2:    begin w_opa = w_u;  w_opb = w_u;  end
            OpU3:    begin w_opa = w_u2; w_opb = w_u;  end
            OpE10:   begin w_opa = $signed({4'b0, r_d}); w_opb = w_h10; end
            OpE11:   begin w_opa = $signed({4'b0, r_d}); w_opb = w_h11; end
            OpV0:    begin w_opa = 36'(signed'(r_vl)); w_opb = w_h00; end
            OpV1:    begin w_opa = 36'(signed'(r_vr)); w_opb = w_h01; end
            OpS0:    begin w_opa = 36'(signed'(r_sl)); w_opb = 36'(r_e10); end
            OpS1:    begin w_opa = 36'(signed'(r_sr)); w_opb = 36'(r_e11); end
            default: begin w_opa = '0; w_opb = '0; end
        endcase
    end
    assign w_maga = w_opa[35] ? -w_opa : w_opa;
    assign w_magb = w_opb[35] ? -w_opb : w_opb;
    assign w_mul  = w_maga[32:0] * w_magb[32:0];

    // round to nearest, ties away from zero, then restore sign
    logic               w_sh16;
    logic [66:0]        w_rnd;
    logic [50:0]        w_rmag;
    logic signed [51:0] w_term;
    logic signed [53:0] w_acc_sum;
    logic [31:0]        w_sat;
    assign w_sh16    = (r_op == OpS0) || (r_op == OpS1);
    assign w_rnd     = {1'b0, r_prod} + (w_sh16 ? 67'h8000 : 67'h8000_0000);
    assign w_rmag    = w_sh16 ? w_rnd[66:16] : 51'(w_rnd[66:32]);
    assign w_term    = r_neg ? -$signed({1'b0, w_rmag}) : $signed({1'b0, w_rmag});
    assign w_acc_sum = ((r_op == OpV0) ? 54'sd0 : r_acc) + 54'(w_term);
    always_comb begin
        priority if (w_acc_sum > 54'sh7FFF_FFFF) begin
            w_sat = 32'h7FFF_FFFF;
        end else if (w_acc_sum < -54'sh8000_0000) begin
            w_sat = 32'h8000_0000;
        end else begin
            w_sat = w_acc_sum[31:0];
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_eval) n_state = S_K0;
            S_K0: begin
                if (r_n == CW'(1) || r_f <= $signed(w_rkey.frame)) n_state = S_DONE;
                else n_state = S_KL;
            end
            S_KL:    n_state = (r_f >= $signed(w_rkey.frame)) ? S_DONE : S_PROBE;
            S_PROBE: n_state = w_adjacent ? S_RR : S_CMP;
            S_CMP:   n_state = S_PROBE;
            S_RR: begin
                if (w_near) n_state = (r_hm && w_has_next) ? S_R1 : S_DONE;
                else n_state = S_LR;
            end
            S_R1:    n_state = S_DONE;
            S_LR:    n_state = r_hm ? S_DIV : S_DONE;
            S_DIV:   if (r_cnt == 5'd31) n_state = S_MUL;
            S_MUL:   if (r_phase && r_op == OpS1) n_state = S_DONE;
            S_DONE:  if (!r_out_valid || m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_key_count  <= 9'd1;
            r_curve_mode <= 1'b1;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && (!r_out_valid || m_axis_tready)) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index[0])
                    kce_pkg::CfgKeyCount:  r_key_count  <= i_cfg_data;
                    kce_pkg::CfgCurveMode: r_curve_mode <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_eval) begin
                    r_n  <= w_n_eff;
                    r_hm <= r_curve_mode;
                    r_f  <= $signed(s_axis_tdata[135:104]);
                end
            end
            S_K0: begin
                r_val <= w_rkey_val;
                r_seg <= '0;
            end
            S_KL: begin
                r_val   <= w_rkey_val;
                r_seg   <= w_last;
                r_left  <= '0;
                r_right <= w_last;
            end
            S_CMP: begin
                if (w_go_right) r_right <= w_mid;
                else r_left <= w_mid;
            end
            S_RR: begin
                r_seg <= r_left;
                r_fr  <= w_rkey.frame;
                r_vr  <= w_rkey.value;
                r_sr  <= w_rkey.slope;
                r_val <= w_rkey_val;
            end
            S_R1: begin
                if (w_rkey.frame != r_fr) r_val <= r_vr;
                else r_val <= w_rkey.value;
            end
            S_LR: begin
                r_val <= w_rkey_val;
                r_vl  <= w_rkey.value;
                r_sl  <= w_rkey.slope;
                // left < query < right, so both differences are positive
                r_d   <= r_fr - w_rkey.frame;
                r_dh  <= {1'b0, r_fr[31:1] - w_rkey.frame[31:1]
                          - 31'(~r_fr[0] & w_rkey.frame[0])};
                r_rem <= {1'b0, r_f - $signed(w_rkey.frame)};
                r_cnt <= '0;
            end
            S_DIV: begin
                r_rem   <= w_ge ? (w_rem_sh - {1'b0, r_d}) : w_rem_sh;
                r_q     <= {r_q[30:0], w_ge};
                r_dh    <= {r_dh[30:0], 1'b0};
                r_cnt   <= r_cnt + 5'd1;
                r_op    <= OpU2;
                r_phase <= 1'b0;
            end
            S_MUL: begin
                r_phase <= ~r_phase;
                if (!r_phase) begin
                    r_prod <= w_mul;
                    r_neg  <= w_opa[35] ^ w_opb[35];
                end else begin
                    r_op <= r_op + 3'd1;
                    unique case (r_op)
                        OpU2:    r_u2  <= w_rmag[31:0];
                        OpU3:    r_u3  <= w_rmag[31:0];
                        OpE10:   r_e10 <= w_term[33:0];
                        OpE11:   r_e11 <= w_term[33:0];
                        OpS1:    r_val <= w_sat;
                        default: r_acc <= w_acc_sum;
                    endcase
                end
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    r_out_data <= {8'(r_seg), r_val};
                end
            end
            default: ;
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`include "keyframe_curve_evaluator_top_macros.svh"
    `KCE_ASSERT_SAME(a_probe_order, r_state == S_PROBE, r_left < r_right)
    `KCE_ASSERT_SAME(a_div_rem, r_state == S_DIV, r_rem < {1'b0, r_d})
    `KCE_ASSERT_NEXT(a_eval_busy, w_eval, r_state == S_K0)
endmodule

// ===== sim/tb.sv =====
// Testbench for the keyframe curve evaluator: random key tables and queries checked beat by beat.
`timescale 1ns / 100ps

module tb;
    localparam int NKEYS = 256;
    localparam longint CYCLE_LIMIT = 2000000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata = '0;
    logic [0:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [39:0]  m_axis_tdata;
    logic         i_cfg_we = 1'b0;
    logic [0:0]   i_cfg_index = '0;
    logic [8:0]   i_cfg_data = '0;

    keyframe_curve_evaluator_top dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // packed from the top down: command in tuser, then tdata from query down to index
    typedef struct packed {
        logic        cmd;
        logic [31:0] qframe;
        logic [31:0] kslope;
        logic [31:0] kvalue;
        logic [31:0] kframe;
        logic [7:0]  idx;
    } t_beat;

    typedef struct packed {
        logic [31:0] value;
        logic [7:0]  seg;
    } t_curve_out;

    // predictor state
    logic [31:0] frm_tbl [NKEYS];
    logic [31:0] val_tbl [NKEYS];
    logic [31:0] slp_tbl [NKEYS];
    int unsigned cur_count = 1;
    bit          cur_hermite = 1'b1;

    t_beat      pending_beats [$];
    t_curve_out expected_curve [$];
    int errors = 0;
    int mismatches = 0;
    int loads_sent = 0, evals_sent = 0, results_seen = 0;
    longint cycles = 0;
    bit hold_off = 1'b0;

    // round to nearest, ties away from zero
    function automatic longint scaled_product(longint a, longint b, int sh);
        bit neg;
        logic [127:0] m;
        longint r;
        neg = (a < 0) != (b < 0);
        m = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
        m = (m + (128'(1) << (sh - 1))) >> sh;
        r = longint'(m[62:0]);
        return neg ? -r : r;
    endfunction

    function automatic bit is_near(longint f, int k);
        longint c;
        c = f - longint'($signed(frm_tbl[k]));
        return c > -kce_pkg::TolLsb && c < kce_pkg::TolLsb;
    endfunction

    function automatic longint hermite_blend(longint f, int l, int r);
        longint fl, t1, d, u, u2, u3, h00, h01, h10, h11, e10, e11, sum;
        logic [127:0] q;
        fl = $signed(frm_tbl[l]);
        t1 = f - fl;
        d = longint'($signed(frm_tbl[r])) - fl;
        if (d == 0) d = 1;
        q = ((128'(t1) << 32) + 128'(d >> 1)) / 128'(d);
        u = longint'(q[63:0]);
        q = 128'(u) * 128'(u) + 128'h8000_0000;
        u2 = longint'(q[95:32]);
        q = 128'(u2) * 128'(u) + 128'h8000_0000;
        u3 = longint'(q[95:32]);
        h00 = 2 * u3 - 3 * u2 + 64'h1_0000_0000;
        h01 = 3 * u2 - 2 * u3;
        h10 = u3 - 2 * u2 + u;
        h11 = u3 - u2;
        e10 = scaled_product(d, h10, 32);
        e11 = scaled_product(d, h11, 32);
        sum = scaled_product($signed(val_tbl[l]), h00, 32)
            + scaled_product($signed(val_tbl[r]), h01, 32)
            + scaled_product($signed(slp_tbl[l]), e10, 16)
            + scaled_product($signed(slp_tbl[r]), e11, 16);
        if (sum > 64'sd2147483647) sum = 64'sd2147483647;
        if (sum < -64'sd2147483648) sum = -64'sd2147483648;
        return sum;
    endfunction

    function automatic longint key_level(int k);
        return cur_hermite ? longint'($signed(val_tbl[k])) : longint'(val_tbl[k][15:0]);
    endfunction

    // apply one accepted beat to the predictor
    function automatic void predict_curve(t_beat b);
        int n, lo, hi, mid, k;
        longint f, v;
        bit go_hi;
        t_curve_out e;
        if (b.cmd == kce_pkg::CmdLoad) begin
            frm_tbl[b.idx] = b.kframe;
            val_tbl[b.idx] = b.kvalue;
            slp_tbl[b.idx] = b.kslope;
            return;
        end
        n = cur_count < 1 ? 1 : (cur_count > NKEYS ? NKEYS : cur_count);
        f = $signed(b.qframe);
        if (n == 1 || f <= longint'($signed(frm_tbl[0]))) begin
            e.seg = 0;
            v = key_level(0);
        end else if (f >= longint'($signed(frm_tbl[n - 1]))) begin
            e.seg = 8'(n - 1);
            v = key_level(n - 1);
        end else begin
            lo = 0;
            hi = n - 1;
            while (lo + 1 != hi && lo != hi) begin
                mid = (lo + hi) / 2;
                go_hi = cur_hermite ? (f <= longint'($signed(frm_tbl[mid])))
                                    : (f < longint'($signed(frm_tbl[mid])));
                if (go_hi) hi = mid;
                else lo = mid;
            end
            e.seg = 8'(lo);
            if (!cur_hermite) begin
                k = is_near(f, hi) ? hi : lo;
                v = val_tbl[k][15:0];
            end else if (is_near(f, hi)) begin
                // duplicate key frame: take the later key
                if (hi + 1 < n && frm_tbl[hi] == frm_tbl[hi + 1]) v = $signed(val_tbl[hi + 1]);
                else v = $signed(val_tbl[hi]);
            end else begin
                v = hermite_blend(f, lo, hi);
            end
        end
        e.value = v[31:0];
        expected_curve.push_back(e);
    endfunction

    // random gap: mostly none or short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // driver
    int drv_gap = 0;
    bit no_idle = 1'b0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_curve(t_beat'({s_axis_tuser, s_axis_tdata}));
                void'(pending_beats.pop_front());
                drv_gap = no_idle ? 0 : gap_len();
            end
            if (drv_gap > 0) begin
                drv_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                {s_axis_tuser, s_axis_tdata} <= pending_beats[0];
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    int mon_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (expected_curve.size() == 0) begin
                    errors++;
                    if (mismatches++ < 10) $display("unexpected result %h", m_axis_tdata);
                end else begin
                    t_curve_out e;
                    e = expected_curve.pop_front();
                    if (m_axis_tdata[31:0] !== e.value || m_axis_tdata[39:32] !== e.seg) begin
                        errors++;
                        if (mismatches++ < 10)
                            $display("mismatch: value exp %h got %h, seg exp %0d got %0d",
                                     e.value, m_axis_tdata[31:0], e.seg, m_axis_tdata[39:32]);
                    end
                end
                mon_gap = no_idle ? 0 : gap_len();
            end
            if (hold_off) m_axis_tready <= 1'b0;
            else if (mon_gap > 0) begin
                mon_gap--;
                m_axis_tready <= 1'b0;
            end else m_axis_tready <= 1'b1;
        end
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic t_beat load_beat(int k, logic [31:0] fr, logic [31:0] va, logic [31:0] sl);
        t_beat b;
        b = '0;
        b.cmd = kce_pkg::CmdLoad;
        b.idx = 8'(k);
        b.kframe = fr;
        b.kvalue = va;
        b.kslope = sl;
        b.qframe = $urandom();
        return b;
    endfunction

    task automatic queue_load(int k, logic [31:0] fr, logic [31:0] va, logic [31:0] sl);
        pending_beats.push_back(load_beat(k, fr, va, sl));
        loads_sent++;
    endtask

    task automatic queue_eval(logic [31:0] q);
        t_beat b;
        b = '0;
        b.cmd = kce_pkg::CmdEval;
        b.idx = $urandom();
        b.kframe = $urandom();
        b.kvalue = $urandom();
        b.kslope = $urandom();
        b.qframe = q;
        pending_beats.push_back(b);
        evals_sent++;
    endtask

    task automatic drain();
        while (pending_beats.size() > 0 || s_axis_tvalid || expected_curve.size() > 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [8:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == kce_pkg::CfgKeyCount) cur_count = data;
        else cur_hermite = data[0];
    endtask

    // ascending keys with random spacing; some duplicates and tight steps
    task automatic load_table(int n, int spread);
        longint fr;
        int k;
        fr = -64'sd2147483648 + longint'($urandom_range(0, 1 << 20)) * spread;
        if (spread == 0) fr = -64'sd1000000;
        for (k = 0; k < n; k++) begin
            if (fr > 64'sd2147483647) fr = 64'sd2147483647;
            queue_load(k, fr[31:0], $urandom(), $urandom());
            case ($urandom_range(0, 9))
                0: fr = fr;
                1: fr += $urandom_range(1, 80);
                default: fr += spread == 0 ? $urandom_range(100, 200000)
                                           : longint'($urandom_range(1, 1 << 16)) * spread;
            endcase
        end
    endtask

    function automatic logic [31:0] pick_query(int n);
        int k;
        longint q;
        k = $urandom_range(0, n - 1);
        case ($urandom_range(0, 5))
            0: q = $signed(frm_tbl[k]);
            1: q = longint'($signed(frm_tbl[k])) + $urandom_range(0, 130) - 65;
            2: return $urandom();
            default: q = longint'($signed(frm_tbl[k])) + $urandom_range(0, 400000) - 200000;
        endcase
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        return q[31:0];
    endfunction

    // frames in the predictor table are only known after the loads are taken,
    // so each phase loads, drains, then queries
    task automatic run_phase(int n, bit herm, int spread, int queries);
        int i;
        load_table(n, spread);
        drain();
        write_reg(kce_pkg::CfgKeyCount, 9'(n));
        write_reg(kce_pkg::CfgCurveMode, 9'(herm));
        for (i = 0; i < queries; i++) queue_eval(pick_query(n));
        drain();
    endtask

    initial begin
        int p, n;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset state (one key, Hermite), field extremes
        queue_load(0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_load(1, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_load(2, 32'h0000_0000, 32'hFFFF_1234, 32'hFFFF_FFFF);
        queue_load(3, 32'h7FFF_FFFF, 32'h0000_FFFF, 32'h0000_0000);
        queue_load(255, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_eval(32'h8000_0000);
        queue_eval(32'h7FFF_FFFF);
        drain();
        write_reg(kce_pkg::CfgKeyCount, 9'd4);
        queue_eval(32'h8000_0000);
        queue_eval(32'hC000_0000);
        queue_eval(32'h0000_0000);        // duplicate frame hit
        queue_eval(32'h0000_0041);        // just inside tolerance
        queue_eval(32'h0000_0042);        // just outside tolerance
        queue_eval(32'h7FFF_FFFF);
        drain();
        write_reg(kce_pkg::CfgCurveMode, 9'd0);
        queue_eval(32'hC000_0000);
        queue_eval(32'hFFFF_FFBF);
        queue_eval(32'h0000_0000);
        queue_eval(32'h7FFF_FFF0);
        drain();
        write_reg(kce_pkg::CfgKeyCount, 9'd0);     // acts as one key
        queue_eval(32'h1234_5678);
        drain();
        write_reg(kce_pkg::CfgKeyCount, 9'd511);   // acts as the full table
        queue_eval(32'h7FFF_FFFF);                 // clamps to the last slot
        drain();

        // full table in both modes
        run_phase(256, 1'b1, 8, 40);
        run_phase(256, 1'b0, 8, 40);

        // long receiver hold-off while the sender keeps offering
        for (p = 0; p < 30; p++) queue_eval(pick_query(256));
        hold_off = 1'b1;
        repeat (2000) @(posedge i_clk);
        hold_off = 1'b0;
        drain();

        // random phases, mostly small tables
        for (p = 0; p < 20; p++) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 256) : $urandom_range(1, 12);
            no_idle = ($urandom_range(0, 4) == 0);
            run_phase(n, $urandom_range(0, 1), $urandom_range(0, 3), 25);
        end
        no_idle = 1'b0;

        $display("ran %0d loads and %0d evaluations, %0d results checked",
                 loads_sent, evals_sent, results_seen);
        $display("covered step and Hermite curves, clamps, tolerance hits, duplicate keys");
        if (errors == 0 && expected_curve.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches, %0d expectations left", errors, expected_curve.size());
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/kce_pkg.sv
rtl/kce_ram.sv
rtl/keyframe_curve_evaluator_top.sv
sim/tb.sv
